// File: hdl/cubic_bezier_segment_sampler_unit_macros.svh
// Assertion macros shared by the Bezier sampler RTL.
`ifndef CUBIC_BEZIER_SEGMENT_SAMPLER_UNIT_MACROS_SVH
`define CUBIC_BEZIER_SEGMENT_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BZS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BZS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/bzs_pkg.sv
// Shared types and constants of the Bezier segment sampler.
`default_nettype none
package bzs_pkg;

   localparam int COORD_BITS      = 10;
   localparam int STEP_BITS       = 6;
   localparam int SQ_BITS         = 2 * STEP_BITS;           // k^2, (N-k)^2, N^2
   localparam int W_BITS          = 3 * STEP_BITS;           // Bernstein weights, N^3
   localparam int PROD_BITS       = W_BITS + COORD_BITS;     // weight * coordinate
   localparam int NUM_BITS        = PROD_BITS + 1;           // 2*S + N^3
   localparam int DEN_BITS        = W_BITS + 1;              // 2*N^3
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [STEP_BITS-1:0] STEP_COUNT_RESET = STEP_BITS'(63);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [STEP_BITS-1:0]  step_type;

   // One segment: four control points
   typedef struct packed {
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p3_x;
      coord_type p3_y;
   } req_type;

   // One sampled curve point
   typedef struct packed {
      coord_type  point_x;
      coord_type  point_y;
      step_type   step_index;
      logic       last_point;
   } rsp_type;

   // Queue entry: segment plus its effective step count
   typedef struct packed {
      req_type  pts;
      step_type n;
   } seg_type;

   // Work handed from the sum stages to the divider
   typedef struct packed {
      logic [NUM_BITS-1:0] num_x;
      logic [NUM_BITS-1:0] num_y;
      logic [DEN_BITS-1:0] den;
      step_type            step;
      logic                last;
   } div_in_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SQUARE,
      ENG_CUBE,
      ENG_RUN
   } eng_state_type;

endpackage
`default_nettype wire

// File: hdl/bzs_front.sv
// Front end: accepts segments, resolves the step count, queues them.
`default_nettype none
module bzs_front #(
   parameter int DEPTH = bzs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bzs_pkg::req_type req_data,
   input  bzs_pkg::step_type step_count,
   input  logic             pop,
   output logic             seg_valid,
   output bzs_pkg::seg_type seg
);
   import bzs_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   seg_type             entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;
   seg_type             seg_new;

   assign req_ready = (count_ff != CNT_BITS'(DEPTH));
   assign push      = req_valid && req_ready;
   assign seg_valid = (count_ff != '0);
   assign seg       = entry_ff[rd_ptr_ff];

   // classify: a step count of zero runs as one interval
   always_comb begin
      seg_new.pts = req_data;
      seg_new.n   = (step_count == '0) ? STEP_BITS'(1) : step_count;
   end

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= seg_new;
      end
   end

endmodule
`default_nettype wire

// File: hdl/bzs_engine.sv
// Back end: step sequencer, Bernstein weights and weighted sums.
`default_nettype none
module bzs_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                seg_valid,
   input  bzs_pkg::seg_type    seg,
   output logic                seg_pop,
   output logic                div_valid,
   output bzs_pkg::div_in_type div_data
);
   import bzs_pkg::*;

   // sequencer
   eng_state_type       state_ff, state_in;
   req_type             pts_ff, pts_in;
   step_type            n_ff, n_in;
   step_type            k_ff, k_in;
   logic [SQ_BITS-1:0]  nsq_ff, nsq_in;
   logic [W_BITS-1:0]   cube_ff, cube_in;
   logic                issue;

   // stage 1: a = N - k
   logic                v1_ff;
   step_type            a1_ff, a1_in, k1_ff;
   logic                last1_ff, last1_in;
   req_type             pts1_ff;
   logic [W_BITS-1:0]   cube1_ff;

   // stage 2: squares
   logic                v2_ff;
   logic [SQ_BITS-1:0]  asq2_ff, asq2_in, ksq2_ff, ksq2_in;
   step_type            a2_ff, k2_ff;
   logic                last2_ff;
   req_type             pts2_ff;
   logic [W_BITS-1:0]   cube2_ff;

   // stage 3: weights
   logic                v3_ff;
   logic [W_BITS-1:0]   w3_ff [4];
   logic [W_BITS-1:0]   w3_in [4];
   logic [W_BITS-1:0]   t1, t2;
   step_type            k3_ff;
   logic                last3_ff;
   req_type             pts3_ff;
   logic [W_BITS-1:0]   cube3_ff;

   // stage 4: weighted coordinates
   logic                v4_ff;
   logic [PROD_BITS-1:0] px4_ff [4];
   logic [PROD_BITS-1:0] py4_ff [4];
   logic [PROD_BITS-1:0] px4_in [4];
   logic [PROD_BITS-1:0] py4_in [4];
   step_type            k4_ff;
   logic                last4_ff;
   logic [W_BITS-1:0]   cube4_ff;

   // stage 5: rounded numerator and denominator
   logic                v5_ff;
   div_in_type          div_ff, div_in;
   logic [PROD_BITS-1:0] sum_x, sum_y;

   // next state
   always_comb begin
      state_in = state_ff;
      if (en) begin
         case (state_ff)
            ENG_IDLE:   if (seg_valid) state_in = ENG_SQUARE;
            ENG_SQUARE: state_in = ENG_CUBE;
            ENG_CUBE:   state_in = ENG_RUN;
            ENG_RUN:    if (k_ff == n_ff) state_in = ENG_IDLE;
            default:    state_in = ENG_IDLE;
         endcase
      end
   end

   // sequencer outputs
   always_comb begin
      seg_pop = 1'b0;
      issue   = 1'b0;
      case (state_ff)
         ENG_IDLE: seg_pop = en && seg_valid;
         ENG_RUN:  issue   = 1'b1;
         default: begin
            seg_pop = 1'b0;
            issue   = 1'b0;
         end
      endcase
   end

   // segment registers, N^2 and N^3 formed in the SQUARE and CUBE setup states
   always_comb begin
      pts_in  = pts_ff;
      n_in    = n_ff;
      k_in    = k_ff;
      nsq_in  = nsq_ff;
      cube_in = cube_ff;
      if (seg_pop) begin
         pts_in = seg.pts;
         n_in   = seg.n;
         k_in   = '0;
      end
      if (state_ff == ENG_SQUARE) begin
         nsq_in = SQ_BITS'(n_ff) * SQ_BITS'(n_ff);
      end
      if (state_ff == ENG_CUBE) begin
         cube_in = W_BITS'(nsq_ff) * W_BITS'(n_ff);
      end
      if (issue) begin
         k_in = k_ff + 1'b1;
      end
   end

   // stage datapaths
   always_comb begin
      a1_in    = n_ff - k_ff;
      last1_in = (k_ff == n_ff);

      asq2_in = SQ_BITS'(a1_ff) * SQ_BITS'(a1_ff);
      ksq2_in = SQ_BITS'(k1_ff) * SQ_BITS'(k1_ff);

      t1       = W_BITS'(asq2_ff) * W_BITS'(k2_ff);
      t2       = W_BITS'(ksq2_ff) * W_BITS'(a2_ff);
      w3_in[0] = W_BITS'(asq2_ff) * W_BITS'(a2_ff);
      w3_in[1] = (t1 << 1) + t1;
      w3_in[2] = (t2 << 1) + t2;
      w3_in[3] = W_BITS'(ksq2_ff) * W_BITS'(k2_ff);

      px4_in[0] = PROD_BITS'(w3_ff[0]) * PROD_BITS'(pts3_ff.p0_x);
      px4_in[1] = PROD_BITS'(w3_ff[1]) * PROD_BITS'(pts3_ff.p1_x);
      px4_in[2] = PROD_BITS'(w3_ff[2]) * PROD_BITS'(pts3_ff.p2_x);
      px4_in[3] = PROD_BITS'(w3_ff[3]) * PROD_BITS'(pts3_ff.p3_x);
      py4_in[0] = PROD_BITS'(w3_ff[0]) * PROD_BITS'(pts3_ff.p0_y);
      py4_in[1] = PROD_BITS'(w3_ff[1]) * PROD_BITS'(pts3_ff.p1_y);
      py4_in[2] = PROD_BITS'(w3_ff[2]) * PROD_BITS'(pts3_ff.p2_y);
      py4_in[3] = PROD_BITS'(w3_ff[3]) * PROD_BITS'(pts3_ff.p3_y);

      // S never exceeds N^3 times the largest coordinate
      sum_x = px4_ff[0] + px4_ff[1] + px4_ff[2] + px4_ff[3];
      sum_y = py4_ff[0] + py4_ff[1] + py4_ff[2] + py4_ff[3];
      div_in.num_x = (NUM_BITS'(sum_x) << 1) + NUM_BITS'(cube4_ff);
      div_in.num_y = (NUM_BITS'(sum_y) << 1) + NUM_BITS'(cube4_ff);
      div_in.den   = {cube4_ff, 1'b0};
      div_in.step  = k4_ff;
      div_in.last  = last4_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (en) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
         end
      end
   end

   // payload, all advancing together with the output stage
   always_ff @(posedge clock) begin
      if (en) begin
         pts_ff   <= pts_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         nsq_ff   <= nsq_in;
         cube_ff  <= cube_in;

         a1_ff    <= a1_in;
         k1_ff    <= k_ff;
         last1_ff <= last1_in;
         pts1_ff  <= pts_ff;
         cube1_ff <= cube_ff;

         asq2_ff  <= asq2_in;
         ksq2_ff  <= ksq2_in;
         a2_ff    <= a1_ff;
         k2_ff    <= k1_ff;
         last2_ff <= last1_ff;
         pts2_ff  <= pts1_ff;
         cube2_ff <= cube1_ff;

         w3_ff    <= w3_in;
         k3_ff    <= k2_ff;
         last3_ff <= last2_ff;
         pts3_ff  <= pts2_ff;
         cube3_ff <= cube2_ff;

         px4_ff   <= px4_in;
         py4_ff   <= py4_in;
         k4_ff    <= k3_ff;
         last4_ff <= last3_ff;
         cube4_ff <= cube3_ff;

         div_ff   <= div_in;
      end
   end

   assign div_valid = v5_ff;
   assign div_data  = div_ff;

endmodule
`default_nettype wire

// File: hdl/bzs_divider.sv
// Pipelined restoring divider: one quotient bit per stage, x and y lanes.
`default_nettype none
module bzs_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  bzs_pkg::div_in_type in_data,
   output logic                out_valid,
   output bzs_pkg::rsp_type    out_data
);
   import bzs_pkg::*;

   localparam int STAGES = COORD_BITS;

   logic                v_ff    [STAGES];
   logic [NUM_BITS-1:0] rx_ff   [STAGES];
   logic [NUM_BITS-1:0] ry_ff   [STAGES];
   coord_type           qx_ff   [STAGES];
   coord_type           qy_ff   [STAGES];
   logic [DEN_BITS-1:0] den_ff  [STAGES];
   step_type            step_ff [STAGES];
   logic                last_ff [STAGES];

   logic [NUM_BITS-1:0] dsh     [STAGES];
   logic [NUM_BITS-1:0] rx_in   [STAGES];
   logic [NUM_BITS-1:0] ry_in   [STAGES];
   coord_type           qx_in   [STAGES];
   coord_type           qy_in   [STAGES];

   // each stage tries the shifted divisor against its remainder
   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         dsh[s] = NUM_BITS'(den_ff[s]) << (STAGES - 1 - s);
         rx_in[s] = rx_ff[s];
         ry_in[s] = ry_ff[s];
         qx_in[s] = qx_ff[s];
         qy_in[s] = qy_ff[s];
         if (rx_ff[s] >= dsh[s]) begin
            rx_in[s] = rx_ff[s] - dsh[s];
            qx_in[s] = qx_ff[s] | (COORD_BITS'(1) << (STAGES - 1 - s));
         end
         if (ry_ff[s] >= dsh[s]) begin
            ry_in[s] = ry_ff[s] - dsh[s];
            qy_in[s] = qy_ff[s] | (COORD_BITS'(1) << (STAGES - 1 - s));
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0]   <= in_data.num_x;
         ry_ff[0]   <= in_data.num_y;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         den_ff[0]  <= in_data.den;
         step_ff[0] <= in_data.step;
         last_ff[0] <= in_data.last;
         for (int s = 1; s < STAGES; s++) begin
            rx_ff[s]   <= rx_in[s-1];
            ry_ff[s]   <= ry_in[s-1];
            qx_ff[s]   <= qx_in[s-1];
            qy_ff[s]   <= qy_in[s-1];
            den_ff[s]  <= den_ff[s-1];
            step_ff[s] <= step_ff[s-1];
            last_ff[s] <= last_ff[s-1];
         end
      end
   end

   // the last quotient bit resolves straight into the output register
   assign out_valid           = v_ff[STAGES-1];
   assign out_data.point_x    = qx_in[STAGES-1];
   assign out_data.point_y    = qy_in[STAGES-1];
   assign out_data.step_index = step_ff[STAGES-1];
   assign out_data.last_point = last_ff[STAGES-1];

endmodule
`default_nettype wire

// File: hdl/cubic_bezier_segment_sampler_unit.sv
// Top level of the cubic Bezier segment sampler.
`default_nettype none
`include "cubic_bezier_segment_sampler_unit_macros.svh"

// Takes one cubic Bezier segment per transaction and returns N+1 points at
// t = k/N, k = 0..N, N = step_count (a count of zero runs as one), each
// point exact and rounded half up, the final one flagged by last_point.
// A segment passes the sequencer states in order: IDLE takes it from the
// input queue, SQUARE and CUBE form N^2 and N^3, then RUN issues one point
// per cycle while the back end is not stalled. Each point then goes through
// the weight, multiply and one-bit-per-stage divider pipeline to the output
// register. The input queue holds QUEUE_DEPTH segments so new ones are
// taken while a run is going. A stall on the result side freezes the whole
// back end. step_count may only be written while the block is idle.
module cubic_bezier_segment_sampler_unit #(
   parameter int QUEUE_DEPTH = bzs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bzs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bzs_pkg::rsp_type  rsp_data,
   input  logic              csr_write_en,
   input  bzs_pkg::step_type csr_write_data
);
   import bzs_pkg::*;

   step_type    step_count_ff, step_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        en;
   logic        seg_valid, seg_pop;
   seg_type     seg;
   logic        div_valid, out_valid;
   div_in_type  div_data;
   rsp_type     out_data;

   // back end advances whenever the output register is free or draining
   assign en = !rsp_valid_ff || rsp_ready;

   bzs_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .step_count (step_count_ff),
      .pop        (seg_pop),
      .seg_valid  (seg_valid),
      .seg        (seg)
   );

   bzs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .seg_valid (seg_valid),
      .seg       (seg),
      .seg_pop   (seg_pop),
      .div_valid (div_valid),
      .div_data  (div_data)
   );

   bzs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   // step count register and output register
   always_comb begin
      step_count_in = csr_write_en ? csr_write_data : step_count_ff;
      rsp_valid_in  = en ? out_valid : rsp_valid_ff;
      rsp_data_in   = en ? out_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= STEP_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_count_ff <= step_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // points of one segment follow each other without gaps, in step order
   `BZS_ASSERT_NEXT(a_step_follows, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_point, rsp_valid && (rsp_data.step_index == $past(rsp_data.step_index) + STEP_BITS'(1)), "point of a segment missing or out of order")
   // a run always has at least one interval
   `BZS_ASSERT_IMPLIES(a_last_nonzero, clock, reset, rsp_valid && rsp_data.last_point, rsp_data.step_index != '0, "last point flagged at step zero")
   // the queue fills only through accepted transactions
   `BZS_ASSERT_IMPLIES(a_queue_fill, clock, reset, !req_ready, $past(!req_ready) || $past(req_valid && req_ready), "input queue full without a transaction")

endmodule
`default_nettype wire

// File: bench/cubic_bezier_segment_sampler_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the cubic Bezier segment sampler against an exact integer model.
module cubic_bezier_segment_sampler_unit_tb;
   import bzs_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 40;          // setup + weight/divider pipeline, with margin
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int MAX_REPORTS   = 10;
   localparam int SEG_BITS      = $bits(req_type);

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid;
   logic     req_ready;
   req_type  req_data;
   logic     rsp_valid;
   logic     rsp_ready;
   rsp_type  rsp_data;
   logic     csr_write_en;
   step_type csr_write_data;

   // Bench copy of the step count register
   step_type    step_count_shadow = STEP_COUNT_RESET;
   // Curve points still owed by the block, oldest first
   rsp_type     expected_points[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;
   int unsigned receiver_hold_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cubic_bezier_segment_sampler_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Gap length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Bernstein-weighted sum over n^3, rounded half up, all in exact integers
   function automatic coord_type blend_coord(int unsigned n, int unsigned k,
                                             coord_type c0, coord_type c1,
                                             coord_type c2, coord_type c3);
      longint unsigned a;
      longint unsigned kk;
      longint unsigned sum;
      longint unsigned den;
      a   = n - k;
      kk  = k;
      sum = a * a * a * c0 + 3 * a * a * kk * c1 + 3 * a * kk * kk * c2 + kk * kk * kk * c3;
      den = longint'(n) * n * n;
      return coord_type'((2 * sum + den) / (2 * den));
   endfunction

   // Queue up the n+1 points one segment must produce
   function automatic void predict_segment_points(req_type seg);
      int unsigned n;
      int unsigned k;
      rsp_type     pt;
      n = (step_count_shadow == '0) ? 1 : step_count_shadow;
      for (k = 0; k <= n; k++) begin
         pt.point_x    = blend_coord(n, k, seg.p0_x, seg.p1_x, seg.p2_x, seg.p3_x);
         pt.point_y    = blend_coord(n, k, seg.p0_y, seg.p1_y, seg.p2_y, seg.p3_y);
         pt.step_index = step_type'(k);
         pt.last_point = (k == n);
         expected_points.push_back(pt);
      end
   endfunction

   function automatic coord_type corner_coord();
      case ($urandom_range(0, 3))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return coord_type'(1);
         end
         default: begin
            return coord_type'(1022);
         end
      endcase
   endfunction

   // Random control points; some degenerate, some pinned to the coordinate limits
   function automatic req_type random_segment();
      logic [7:0][COORD_BITS-1:0] coords;
      coord_type                  same;
      int unsigned                mode;
      int unsigned                i;
      coords = SEG_BITS'({$urandom, $urandom, $urandom});
      mode   = $urandom_range(0, 19);
      if (mode == 0) begin
         same   = coord_type'($urandom_range(0, 1023));
         coords = {8{same}};
      end else if (mode < 4) begin
         for (i = 0; i < 8; i++) begin
            if ($urandom_range(0, 1) == 1) begin
               coords[i] = corner_coord();
            end
         end
      end
      return req_type'(coords);
   endfunction

   // Offer one segment; called just after a falling edge, returns just after one
   task automatic send_segment(req_type seg);
      int unsigned gap;
      req_data  <= seg;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_segment_points(seg);
      gap = sender_idles ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stop offering and wait until every owed point has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Register write; only issued while the block is idle
   task automatic write_step_count(step_type value);
      csr_write_data <= value;
      csr_write_en   <= 1'b1;
      @(negedge clock);
      csr_write_en      <= 1'b0;
      step_count_shadow = value;
   endtask

   // Reset step count of 63 with flat, full-scale and bit-pattern segments
   task automatic test_full_step_extremes();
      send_segment(req_type'('0));
      send_segment(req_type'('1));
      send_segment(req_type'({8{10'h2AA}}));
      send_segment(req_type'({8{10'h155}}));
      send_segment(req_type'({{2{10'h3FF}}, {4{10'h000}}, {2{10'h3FF}}}));
      send_segment(req_type'({{2{10'h000}}, {4{10'h3FF}}, {2{10'h000}}}));
      wait_drained();
   endtask

   // A count of zero runs as one interval: only the two end points
   task automatic test_zero_step_count();
      write_step_count('0);
      send_segment(random_segment());
      send_segment(req_type'('1));
      send_segment(req_type'({{6{10'h000}}, {2{10'h3FF}}}));
      wait_drained();
   endtask

   // With two intervals the midpoint weights are 1,3,3,1 over 8, so exact halves occur
   task automatic test_midpoint_rounding();
      req_type seg;
      write_step_count(step_type'(2));
      seg      = '0;
      seg.p0_x = coord_type'(4);     // 0.5 rounds up to 1
      seg.p0_y = coord_type'(3);     // 0.375 rounds down
      send_segment(seg);
      seg      = '0;
      seg.p1_x = coord_type'(4);     // 1.5 rounds up to 2
      seg.p2_y = coord_type'(1023);
      send_segment(seg);
      seg      = '0;
      seg.p3_x = coord_type'(12);    // 1.5 again, from the far end
      seg.p0_y = coord_type'(5);
      send_segment(seg);
      wait_drained();
   endtask

   // Full-length segments while the receiver holds off: the queue fills and
   // the input stalls; then the sender pauses until all points are back
   task automatic test_input_backpressure();
      write_step_count(step_type'(63));
      sender_idles         = 1'b0;
      receiver_hold_cycles = 500;
      repeat (6) send_segment(random_segment());
      wait_drained();
      sender_idles = 1'b1;
      repeat (4) send_segment(random_segment());
      wait_drained();
   endtask

   // Phases of random segments over many step counts, mostly short runs
   task automatic test_random_segments();
      int unsigned phase;
      int unsigned items;
      step_type    steps;
      for (phase = 0; phase < 12; phase++) begin
         if (phase == 0) begin
            steps = step_type'(1);
         end else if (phase == 1) begin
            steps = step_type'(63);
         end else if (phase % 4 == 3) begin
            steps = step_type'($urandom_range(40, 62));
         end else begin
            steps = step_type'($urandom_range(1, 12));
         end
         items = (steps > 16) ? 8 : 40;
         // one phase runs with no gaps on either side
         sender_idles   = (phase != 5);
         receiver_idles = (phase != 5);
         write_step_count(steps);
         repeat (items) send_segment(random_segment());
         wait_drained();
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Result side: random stalls, plus long hold-offs on request
   initial begin : result_receiver
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (receiver_hold_cycles != 0) begin
            gap                  = receiver_hold_cycles;
            receiver_hold_cycles = 0;
            rsp_ready <= 1'b0;
         end else begin
            gap = receiver_idles ? pick_gap() : 0;
            rsp_ready <= (gap == 0);
         end
         repeat ((gap == 0) ? 1 : gap) @(negedge clock);
      end
   end

   // Compare each accepted point with the oldest owed one
   always @(posedge clock) begin : point_checker
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected point: x=%0d y=%0d k=%0d last=%0b",
                        rsp_data.point_x, rsp_data.point_y,
                        rsp_data.step_index, rsp_data.last_point);
            end
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.point_x !== want.point_x || rsp_data.point_y !== want.point_y ||
                rsp_data.step_index !== want.step_index ||
                rsp_data.last_point !== want.last_point) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $write("point mismatch: expected x=%0d y=%0d k=%0d last=%0b, ",
                         want.point_x, want.point_y, want.step_index, want.last_point);
                  $display("got x=%0d y=%0d k=%0d last=%0b",
                           rsp_data.point_x, rsp_data.point_y,
                           rsp_data.step_index, rsp_data.last_point);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cubic_bezier_segment_sampler_unit verification failed");
         $finish;
      end
   end

   initial begin
      req_valid      = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_full_step_extremes();
      test_zero_step_count();
      test_midpoint_rounding();
      test_input_backpressure();
      test_random_segments();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("cubic_bezier_segment_sampler_unit verification clean");
      end else begin
         $display("cubic_bezier_segment_sampler_unit verification failed");
      end
      $finish;
   end

endmodule
